FILE: sv/lz10_stream_decompressor_unit_assert.svh
// ----------------------------------------------------------------------------
// lz10_stream_decompressor_unit_assert.svh
// Assertion macros for the LZ10 stream decompressor, clocked by clock and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef LZ10_STREAM_DECOMPRESSOR_UNIT_ASSERT_SVH
`define LZ10_STREAM_DECOMPRESSOR_UNIT_ASSERT_SVH

// same-cycle implication
`define LZ10_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LZ10_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/lz10_pkg.sv
// ----------------------------------------------------------------------------
// lz10_pkg
// Shared constants, codes and control structs of the LZ10 stream decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lz10_pkg;

   localparam int DEF_WINDOW_DEPTH = 4096;
   localparam int DEF_SIZE_BITS    = 24;
   localparam int DIST_BITS        = 13;
   localparam int COPY_BITS        = 5;

   localparam logic [7:0] TYPE_BYTE                 = 8'h10;
   localparam logic [COPY_BITS-1:0] MIN_MATCH       = 5'd3;
   localparam logic [3:0] FLAGS_EXHAUSTED           = 4'd8;

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_FLAG   = 2'd1;
   localparam logic [1:0] PH_DATA   = 2'd2;
   localparam logic [1:0] PH_PAIR   = 2'd3;

   localparam logic [1:0] STS_OK         = 2'd0;
   localparam logic [1:0] STS_BAD_HEADER = 2'd1;
   localparam logic [1:0] STS_TRUNCATED  = 2'd2;
   localparam logic [1:0] STS_BAD_REF    = 2'd3;

   localparam logic [3:0] ACT_NONE       = 4'd0;
   localparam logic [3:0] ACT_SKIP       = 4'd1;
   localparam logic [3:0] ACT_HDR_TYPE   = 4'd2;
   localparam logic [3:0] ACT_HDR_SIZE   = 4'd3;
   localparam logic [3:0] ACT_FLAG       = 4'd4;
   localparam logic [3:0] ACT_LIT        = 4'd5;
   localparam logic [3:0] ACT_PAIR_FIRST = 4'd6;
   localparam logic [3:0] ACT_COPY_START = 4'd7;
   localparam logic [3:0] ACT_FAIL       = 4'd8;

   typedef struct packed {
      logic [3:0] act;
      logic [1:0] fail_status;
      logic       copy_issue;
      logic       copy_emit;
   } lz10_cmd_type;

   typedef struct packed {
      logic [1:0] phase;
      logic [1:0] hdr_idx;
      logic       skip;
      logic       type_ok;
      logic       size_zero;
      logic       flag_set;
      logic       lit_short;
      logic       ref_bad;
      logic       pair_short;
      logic       copy_more;
      logic       rd_valid;
      logic       out_free;
   } lz10_status_type;

endpackage

`default_nettype wire

FILE: sv/lz10_stream_decompressor_unit.sv
// ----------------------------------------------------------------------------
// lz10_stream_decompressor_unit
// LZ77 type 0x10 stream decompressor, one compressed byte in per request.
// ----------------------------------------------------------------------------
// Request channel (req_): one compressed byte and an end-of-source flag.
// Response channel (rsp_): one decompressed byte or one error, with run_last
// on the final response of a request and stream_done on the last byte of a
// stream or on an error.
// Header, flag and skipped bytes produce no response.
// A literal or an error shows up in the response register in the cycle
// after it is accepted.
// A back reference of length L (3..18) starts with one window read, then
// moves one byte per cycle into the response register while the receiver
// is not stalling, set by the single read port of the history window memory.
// The next request is taken once the last copy byte is loaded.
// A stalled receiver holds the response register; new requests, and copy
// reads once a read is pending, wait until it drains.
// Reset clears the parser and handshake state and expects a new header.
// The history window is not cleared; a stream only reads what it wrote.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lz10_stream_decompressor_unit_assert.svh"

module lz10_stream_decompressor_unit #(
   parameter int WINDOW_DEPTH = lz10_pkg::DEF_WINDOW_DEPTH,
   parameter int SIZE_BITS    = lz10_pkg::DEF_SIZE_BITS
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_source_byte,
   input  wire logic       req_source_end,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_run_last,
   output logic            rsp_stream_done,
   output logic [1:0]      rsp_status
);
   import lz10_pkg::*;

   lz10_cmd_type    cmd;
   lz10_status_type stat;

   lz10_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_source_end (req_source_end),
      .stat           (stat),
      .req_ready      (req_ready),
      .cmd            (cmd)
   );

   lz10_datapath #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .SIZE_BITS    (SIZE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_source_byte (req_source_byte),
      .req_source_end  (req_source_end),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_done (rsp_stream_done),
      .rsp_status      (rsp_status)
   );

   `LZ10_ASSERT_SAME(a_error_form, rsp_valid && rsp_status != STS_OK,
      rsp_out_byte == 8'd0 && rsp_stream_done && rsp_run_last, "error response malformed")
   `LZ10_ASSERT_SAME(a_done_is_last, rsp_valid && rsp_stream_done, rsp_run_last,
      "stream end not on last response of request")
   `LZ10_ASSERT_NEXT(a_copy_blocks, req_valid && req_ready && cmd.act == ACT_COPY_START,
      !req_ready, "request taken during copy")

endmodule

`default_nettype wire

FILE: sv/lz10_ctrl.sv
// ----------------------------------------------------------------------------
// lz10_ctrl
// Controller: decodes each accepted request into a datapath action and
// sequences the read and emit steps of a back-reference copy.
// ----------------------------------------------------------------------------
`default_nettype none

module lz10_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_source_end,
   input  wire lz10_pkg::lz10_status_type stat,
   output logic                           req_ready,
   output lz10_pkg::lz10_cmd_type         cmd
);
   import lz10_pkg::*;

   localparam logic CS_IDLE = 1'b0;
   localparam logic CS_COPY = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   assign req_ready = (state_ff == CS_IDLE) && stat.out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd             = '0;
      cmd.act         = ACT_NONE;
      cmd.fail_status = STS_OK;
      state_in        = state_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (accept) begin
               priority if (stat.skip) begin
                  cmd.act = ACT_SKIP;
               end else begin
                  unique case (stat.phase)
                     PH_HEADER: begin
                        if (stat.hdr_idx == 2'd0) begin
                           priority if (!stat.type_ok) begin
                              cmd.act         = ACT_FAIL;
                              cmd.fail_status = STS_BAD_HEADER;
                           end else if (req_source_end) begin
                              cmd.act         = ACT_FAIL;
                              cmd.fail_status = STS_TRUNCATED;
                           end else begin
                              cmd.act = ACT_HDR_TYPE;
                           end
                        end else begin
                           priority if (stat.hdr_idx == 2'd3 && stat.size_zero) begin
                              cmd.act         = ACT_FAIL;
                              cmd.fail_status = STS_BAD_HEADER;
                           end else if (req_source_end) begin
                              cmd.act         = ACT_FAIL;
                              cmd.fail_status = STS_TRUNCATED;
                           end else begin
                              cmd.act = ACT_HDR_SIZE;
                           end
                        end
                     end
                     PH_FLAG: begin
                        if (req_source_end) begin
                           cmd.act         = ACT_FAIL;
                           cmd.fail_status = STS_TRUNCATED;
                        end else begin
                           cmd.act = ACT_FLAG;
                        end
                     end
                     PH_DATA: begin
                        priority if (stat.flag_set && req_source_end) begin
                           cmd.act         = ACT_FAIL;
                           cmd.fail_status = STS_TRUNCATED;
                        end else if (stat.flag_set) begin
                           cmd.act = ACT_PAIR_FIRST;
                        end else if (req_source_end && stat.lit_short) begin
                           cmd.act         = ACT_FAIL;
                           cmd.fail_status = STS_TRUNCATED;
                        end else begin
                           cmd.act = ACT_LIT;
                        end
                     end
                     PH_PAIR: begin
                        priority if (stat.ref_bad) begin
                           cmd.act         = ACT_FAIL;
                           cmd.fail_status = STS_BAD_REF;
                        end else if (req_source_end && stat.pair_short) begin
                           cmd.act         = ACT_FAIL;
                           cmd.fail_status = STS_TRUNCATED;
                        end else begin
                           cmd.act  = ACT_COPY_START;
                           state_in = CS_COPY;
                        end
                     end
                     default: cmd.act = ACT_NONE;
                  endcase
               end
            end
         end
         CS_COPY: begin
            cmd.copy_emit  = stat.rd_valid && stat.out_free;
            cmd.copy_issue = stat.copy_more && (!stat.rd_valid || cmd.copy_emit);
            if (cmd.copy_emit && !stat.copy_more) begin
               state_in = CS_IDLE;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/lz10_datapath.sv
// ----------------------------------------------------------------------------
// lz10_datapath
// Datapath: header and flag registers, output counters, history window
// memory with registered read, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lz10_datapath #(
   parameter int WINDOW_DEPTH = lz10_pkg::DEF_WINDOW_DEPTH,
   parameter int SIZE_BITS    = lz10_pkg::DEF_SIZE_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [7:0]             req_source_byte,
   input  wire logic                   req_source_end,
   input  wire lz10_pkg::lz10_cmd_type cmd,
   output lz10_pkg::lz10_status_type   stat,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_run_last,
   output logic                        rsp_stream_done,
   output logic [1:0]                  rsp_status
);
   import lz10_pkg::*;

   localparam int AW = $clog2(WINDOW_DEPTH);

   logic [7:0] window_mem [WINDOW_DEPTH];

   logic [1:0]           phase_ff, phase_in;
   logic [1:0]           hdr_idx_ff, hdr_idx_in;
   logic                 skip_ff, skip_in;
   logic [SIZE_BITS-1:0] declared_ff, declared_in;
   logic [SIZE_BITS-1:0] produced_ff, produced_in;
   logic [7:0]           flag_bits_ff, flag_bits_in;
   logic [3:0]           flag_pos_ff, flag_pos_in;
   logic [7:0]           pair_first_ff, pair_first_in;
   logic [7:0]           last_byte_ff, last_byte_in;
   logic [COPY_BITS-1:0] copy_left_ff, copy_left_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [AW-1:0]        rd_addr_ff, rd_addr_in;
   logic [7:0]           rd_data_ff;
   logic                 dist_one_ff, dist_one_in;
   logic                 pair_end_ff, pair_end_in;
   logic                 pair_final_ff, pair_final_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_byte_ff, rsp_byte_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_done_ff, rsp_done_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   logic [4:0]           size_shift;
   logic [SIZE_BITS-1:0] size_merge;
   logic [7:0]           flag_window;
   logic [SIZE_BITS-1:0] produced_inc;
   logic [SIZE_BITS-1:0] remaining;
   logic [COPY_BITS-1:0] match_len;
   logic [DIST_BITS-1:0] match_dist;
   logic [SIZE_BITS-1:0] match_len_ext;
   logic [SIZE_BITS-1:0] match_dist_ext;
   logic [3:0]           flag_pos_inc;
   logic [7:0]           copy_byte;
   logic                 copy_last;
   logic                 wr_en;
   logic [7:0]           wr_data;
   logic                 out_free;

   assign size_shift     = {hdr_idx_ff - 2'd1, 3'b000};
   assign size_merge     = declared_ff | (SIZE_BITS'(req_source_byte) << size_shift);
   assign flag_window    = flag_bits_ff << flag_pos_ff[2:0];
   assign produced_inc   = produced_ff + SIZE_BITS'(1);
   assign remaining      = declared_ff - produced_ff;
   assign match_len      = {1'b0, pair_first_ff[7:4]} + MIN_MATCH;
   assign match_dist     = {1'b0, pair_first_ff[3:0], req_source_byte} + DIST_BITS'(1);
   assign match_len_ext  = SIZE_BITS'(match_len);
   assign match_dist_ext = SIZE_BITS'(match_dist);
   assign flag_pos_inc   = flag_pos_ff + 4'd1;
   assign copy_byte      = dist_one_ff ? last_byte_ff : rd_data_ff;
   assign copy_last      = (copy_left_ff == '0);
   assign out_free       = !rsp_valid_ff || rsp_ready;

   always_comb begin
      stat            = '0;
      stat.phase      = phase_ff;
      stat.hdr_idx    = hdr_idx_ff;
      stat.skip       = skip_ff;
      stat.type_ok    = (req_source_byte == TYPE_BYTE);
      stat.size_zero  = (size_merge == '0);
      stat.flag_set   = flag_window[7];
      stat.lit_short  = (produced_inc < declared_ff);
      stat.ref_bad    = (match_dist_ext > produced_ff) || (match_len_ext > remaining);
      stat.pair_short = (match_len_ext < remaining);
      stat.copy_more  = !copy_last;
      stat.rd_valid   = rd_valid_ff;
      stat.out_free   = out_free;
   end

   always_comb begin
      phase_in      = phase_ff;
      hdr_idx_in    = hdr_idx_ff;
      skip_in       = skip_ff;
      declared_in   = declared_ff;
      produced_in   = produced_ff;
      flag_bits_in  = flag_bits_ff;
      flag_pos_in   = flag_pos_ff;
      pair_first_in = pair_first_ff;
      last_byte_in  = last_byte_ff;
      copy_left_in  = copy_left_ff;
      rd_valid_in   = rd_valid_ff;
      rd_addr_in    = rd_addr_ff;
      dist_one_in   = dist_one_ff;
      pair_end_in   = pair_end_ff;
      pair_final_in = pair_final_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_data       = req_source_byte;

      unique case (cmd.act)
         ACT_SKIP: begin
            if (req_source_end) begin
               skip_in = 1'b0;
            end
         end
         ACT_HDR_TYPE: begin
            declared_in = '0;
            hdr_idx_in  = 2'd1;
         end
         ACT_HDR_SIZE: begin
            declared_in = size_merge;
            if (hdr_idx_ff == 2'd3) begin
               produced_in = '0;
               flag_pos_in = FLAGS_EXHAUSTED;
               phase_in    = PH_FLAG;
            end else begin
               hdr_idx_in = hdr_idx_ff + 2'd1;
            end
         end
         ACT_FLAG: begin
            flag_bits_in = req_source_byte;
            flag_pos_in  = 4'd0;
            phase_in     = PH_DATA;
         end
         ACT_LIT: begin
            wr_en         = 1'b1;
            wr_data       = req_source_byte;
            produced_in   = produced_inc;
            last_byte_in  = req_source_byte;
            rsp_valid_in  = 1'b1;
            rsp_byte_in   = req_source_byte;
            rsp_last_in   = 1'b1;
            rsp_done_in   = !stat.lit_short;
            rsp_status_in = STS_OK;
            if (!stat.lit_short) begin
               phase_in   = PH_HEADER;
               hdr_idx_in = 2'd0;
               skip_in    = !req_source_end;
            end else begin
               flag_pos_in = flag_pos_inc;
               phase_in    = (flag_pos_inc >= FLAGS_EXHAUSTED) ? PH_FLAG : PH_DATA;
            end
         end
         ACT_PAIR_FIRST: begin
            pair_first_in = req_source_byte;
            phase_in      = PH_PAIR;
         end
         ACT_COPY_START: begin
            copy_left_in  = match_len;
            rd_addr_in    = produced_ff[AW-1:0] - match_dist[AW-1:0];
            dist_one_in   = (match_dist == DIST_BITS'(1));
            pair_end_in   = req_source_end;
            pair_final_in = (match_len_ext == remaining);
         end
         ACT_FAIL: begin
            rsp_valid_in  = 1'b1;
            rsp_byte_in   = 8'd0;
            rsp_last_in   = 1'b1;
            rsp_done_in   = 1'b1;
            rsp_status_in = cmd.fail_status;
            phase_in      = PH_HEADER;
            hdr_idx_in    = 2'd0;
            skip_in       = !req_source_end;
         end
         default: begin
         end
      endcase

      if (cmd.copy_issue) begin
         rd_addr_in   = rd_addr_ff + AW'(1);
         copy_left_in = copy_left_ff - COPY_BITS'(1);
         rd_valid_in  = 1'b1;
      end else if (cmd.copy_emit) begin
         rd_valid_in = 1'b0;
      end

      if (cmd.copy_emit) begin
         wr_en         = 1'b1;
         wr_data       = copy_byte;
         produced_in   = produced_inc;
         last_byte_in  = copy_byte;
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = copy_byte;
         rsp_last_in   = copy_last;
         rsp_done_in   = copy_last && pair_final_ff;
         rsp_status_in = STS_OK;
         if (copy_last) begin
            if (pair_final_ff) begin
               phase_in   = PH_HEADER;
               hdr_idx_in = 2'd0;
               skip_in    = !pair_end_ff;
            end else begin
               flag_pos_in = flag_pos_inc;
               phase_in    = (flag_pos_inc >= FLAGS_EXHAUSTED) ? PH_FLAG : PH_DATA;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         window_mem[produced_ff[AW-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.copy_issue) begin
         rd_data_ff <= window_mem[rd_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hdr_idx_ff   <= 2'd0;
         skip_ff      <= 1'b0;
         copy_left_ff <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hdr_idx_ff   <= hdr_idx_in;
         skip_ff      <= skip_in;
         copy_left_ff <= copy_left_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      declared_ff   <= declared_in;
      produced_ff   <= produced_in;
      flag_bits_ff  <= flag_bits_in;
      flag_pos_ff   <= flag_pos_in;
      pair_first_ff <= pair_first_in;
      last_byte_ff  <= last_byte_in;
      rd_addr_ff    <= rd_addr_in;
      dist_one_ff   <= dist_one_in;
      pair_end_ff   <= pair_end_in;
      pair_final_ff <= pair_final_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_run_last    = rsp_last_ff;
   assign rsp_stream_done = rsp_done_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

`default_nettype wire
